@@ rtl/mgsc_pkg.sv @@
// shared types, constants and register reset values for the mouse gesture servo commander
`timescale 1ns / 1ps
`default_nettype none

package mgsc_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_DEAD_ZONE = 3'd0;
   localparam logic [2:0] CSR_PAN_MAX   = 3'd1;
   localparam logic [2:0] CSR_PAN_MIN   = 3'd2;
   localparam logic [2:0] CSR_TILT_MAX  = 3'd3;
   localparam logic [2:0] CSR_TILT_MIN  = 3'd4;
   localparam logic [2:0] CSR_PAN_ID    = 3'd5;
   localparam logic [2:0] CSR_TILT_ID   = 3'd6;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;

   // register reset values
   localparam logic [7:0] DEAD_ZONE_RST = 8'd5;
   localparam logic [9:0] PAN_MAX_RST   = 10'd850;
   localparam logic [9:0] PAN_MIN_RST   = 10'd240;
   localparam logic [9:0] TILT_MAX_RST  = 10'd812;
   localparam logic [9:0] TILT_MIN_RST  = 10'd212;
   localparam logic [7:0] PAN_ID_RST    = 8'd1;
   localparam logic [7:0] TILT_ID_RST   = 8'd2;

   // servo position reset values
   localparam logic [9:0] PAN_POS_RST  = 10'd550;
   localparam logic [9:0] TILT_POS_RST = 10'd512;

   localparam logic [14:0] COUNT_MAX = 15'h7FFF;
   localparam int          DIV_STEPS = 16;

   // packet bytes
   localparam logic [7:0] SYNC_BYTE   = 8'hFF;
   localparam logic [7:0] WR_LEN      = 8'h07;
   localparam logic [7:0] WR_INST     = 8'h04;
   localparam logic [7:0] WR_ADDR     = 8'h1E;
   localparam logic [7:0] WR_SPD_LO   = 8'hFF;
   localparam logic [7:0] WR_SPD_HI   = 8'h03;
   localparam logic [7:0] WR_SUM_FIX  = 8'(WR_LEN + WR_INST + WR_ADDR + WR_SPD_LO + WR_SPD_HI);
   localparam logic [7:0] BCAST_ID    = 8'hFE;
   localparam logic [7:0] ACT_LEN     = 8'h02;
   localparam logic [7:0] ACT_INST    = 8'h05;
   localparam logic [7:0] ACT_CHK     = 8'hFA;

   localparam logic [3:0] WR_LAST_IDX  = 4'd10;
   localparam logic [3:0] ACT_LAST_IDX = 4'd5;

   typedef struct packed {
      logic signed [15:0] mouse_x;
      logic signed [15:0] mouse_y;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last_byte;
   } rsp_type;

   typedef struct packed {
      logic [7:0] dead_zone;
      logic [9:0] pan_max;
      logic [9:0] pan_min;
      logic [9:0] tilt_max;
      logic [9:0] tilt_min;
      logic [7:0] pan_id;
      logic [7:0] tilt_id;
   } cfg_type;

   // one frame's servo moves, handed from front to back
   typedef struct packed {
      logic       pan_go;
      logic [9:0] pan_pos;
      logic       tilt_go;
      logic [9:0] tilt_pos;
   } cmd_type;

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_DIVX = 4'b0010,
      F_DIVY = 4'b0100,
      F_MOVE = 4'b1000
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE = 4'b0001,
      B_PAN  = 4'b0010,
      B_TILT = 4'b0100,
      B_ACT  = 4'b1000
   } back_state_type;

endpackage

`default_nettype wire

@@ rtl/mgsc_div.sv @@
// iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero
`timescale 1ns / 1ps
`default_nettype none

module mgsc_div import mgsc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [15:0] num,
   input  wire logic [14:0] den,
   output logic             done,
   output logic [15:0]      quot
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic        zden_ff, zden_in;
   logic [14:0] den_ff, den_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] dvd_ff, dvd_in;

   logic [16:0] trial;
   logic [16:0] diff;
   logic        fits;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      zden_in = zden_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      trial   = {rem_ff, dvd_ff[15]};
      diff    = trial - {2'b00, den_ff};
      fits    = (trial >= {2'b00, den_ff});
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 4'd0;
         neg_in  = num[15];
         zden_in = (den == 15'd0);
         den_in  = den;
         rem_in  = 16'd0;
         dvd_in  = num[15] ? (~num + 16'd1) : num;
      end else if (busy_ff) begin
         rem_in = fits ? diff[15:0] : trial[15:0];
         dvd_in = {dvd_ff[14:0], fits};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      zden_ff <= zden_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
   end

   assign done = done_ff;
   assign quot = zden_ff ? 16'd0 : (neg_ff ? (~dvd_ff + 16'd1) : dvd_ff);

endmodule

`default_nettype wire

@@ rtl/mgsc_front.sv @@
// front end: gesture averaging per axis, dead zone test and servo position update
`timescale 1ns / 1ps
`default_nettype none

module mgsc_front import mgsc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    req_push,
   input  wire req_type req_data,
   output logic         req_full,
   output logic         q_push,
   output cmd_type      q_data,
   input  wire logic    q_full
);

   front_state_type state_ff, state_in;

   logic        start_ff, start_in;
   logic        x_act_ff, x_act_in, y_act_ff, y_act_in;
   logic [14:0] x_cnt_ff, x_cnt_in, y_cnt_ff, y_cnt_in;
   logic [15:0] x_sum_ff, x_sum_in, y_sum_ff, y_sum_in;
   logic [15:0] x_pend_ff, x_pend_in, y_pend_ff, y_pend_in;
   logic [9:0]  pan_ff, pan_in, tilt_ff, tilt_in;
   logic        y_end_ff, y_end_in;
   logic [15:0] x_num_ff, x_num_in, y_num_ff, y_num_in;
   logic [14:0] x_den_ff, x_den_in, y_den_ff, y_den_in;

   logic        div_done;
   logic [15:0] div_quot;
   logic [15:0] div_num;
   logic [14:0] div_den;

   logic [15:0]        x_mag, y_mag;
   logic               pan_go, tilt_go;
   logic signed [17:0] pan_wide, tilt_wide;
   logic [9:0]         pan_new, tilt_new;

   function automatic logic [9:0] clamp_pos(logic signed [17:0] v, logic [9:0] hi,
                                            logic [9:0] lo);
      logic signed [17:0] t;
      t = v;
      if (t > $signed({8'd0, hi})) t = $signed({8'd0, hi});
      if (t < $signed({8'd0, lo})) t = $signed({8'd0, lo});
      return t[9:0];
   endfunction

   assign div_num = (state_ff == F_DIVY) ? y_num_ff : x_num_ff;
   assign div_den = (state_ff == F_DIVY) ? y_den_ff : x_den_ff;

   mgsc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      x_mag     = x_pend_ff[15] ? (~x_pend_ff + 16'd1) : x_pend_ff;
      y_mag     = y_pend_ff[15] ? (~y_pend_ff + 16'd1) : y_pend_ff;
      pan_go    = (x_mag > {8'd0, cfg.dead_zone});
      tilt_go   = (y_mag > {8'd0, cfg.dead_zone});
      pan_wide  = $signed({8'd0, pan_ff}) - $signed({{2{x_pend_ff[15]}}, x_pend_ff});
      tilt_wide = $signed({8'd0, tilt_ff}) + $signed({{2{y_pend_ff[15]}}, y_pend_ff});
      pan_new   = clamp_pos(pan_wide, cfg.pan_max, cfg.pan_min);
      tilt_new  = clamp_pos(tilt_wide, cfg.tilt_max, cfg.tilt_min);
   end

   always_comb begin
      state_in  = state_ff;
      start_in  = 1'b0;
      x_act_in  = x_act_ff;
      y_act_in  = y_act_ff;
      x_cnt_in  = x_cnt_ff;
      y_cnt_in  = y_cnt_ff;
      x_sum_in  = x_sum_ff;
      y_sum_in  = y_sum_ff;
      x_pend_in = x_pend_ff;
      y_pend_in = y_pend_ff;
      pan_in    = pan_ff;
      tilt_in   = tilt_ff;
      y_end_in  = y_end_ff;
      x_num_in  = x_num_ff;
      y_num_in  = y_num_ff;
      x_den_in  = x_den_ff;
      y_den_in  = y_den_ff;
      q_push    = 1'b0;
      q_data    = '{pan_go: pan_go, pan_pos: pan_new, tilt_go: tilt_go, tilt_pos: tilt_new};
      unique case (state_ff)
         F_IDLE: begin
            if (req_push) begin
               y_end_in = 1'b0;
               state_in = F_MOVE;
               if (req_data.mouse_x != 16'sd0) begin
                  x_act_in = 1'b1;
                  if (x_cnt_ff != COUNT_MAX) x_cnt_in = x_cnt_ff + 15'd1;
                  x_sum_in = x_sum_ff + $unsigned(req_data.mouse_x);
               end else if (x_act_ff) begin
                  x_num_in = x_sum_ff;
                  x_den_in = x_cnt_ff;
                  x_act_in = 1'b0;
                  x_cnt_in = 15'd0;
                  x_sum_in = 16'd0;
                  state_in = F_DIVX;
                  start_in = 1'b1;
               end
               if (req_data.mouse_y != 16'sd0) begin
                  y_act_in = 1'b1;
                  if (y_cnt_ff != COUNT_MAX) y_cnt_in = y_cnt_ff + 15'd1;
                  y_sum_in = y_sum_ff + $unsigned(req_data.mouse_y);
               end else if (y_act_ff) begin
                  y_num_in = y_sum_ff;
                  y_den_in = y_cnt_ff;
                  y_act_in = 1'b0;
                  y_cnt_in = 15'd0;
                  y_sum_in = 16'd0;
                  y_end_in = 1'b1;
                  if (!(req_data.mouse_x == 16'sd0 && x_act_ff)) begin
                     state_in = F_DIVY;
                     start_in = 1'b1;
                  end
               end
            end
         end
         F_DIVX: begin
            if (div_done) begin
               x_pend_in = div_quot;
               if (y_end_ff) begin
                  state_in = F_DIVY;
                  start_in = 1'b1;
               end else begin
                  state_in = F_MOVE;
               end
            end
         end
         F_DIVY: begin
            if (div_done) begin
               y_pend_in = div_quot;
               state_in  = F_MOVE;
            end
         end
         F_MOVE: begin
            if (!q_full) begin
               q_push = 1'b1;
               if (pan_go) begin
                  pan_in    = pan_new;
                  x_pend_in = 16'd0;
               end
               if (tilt_go) begin
                  tilt_in   = tilt_new;
                  y_pend_in = 16'd0;
               end
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_IDLE;
         start_ff  <= 1'b0;
         x_act_ff  <= 1'b0;
         y_act_ff  <= 1'b0;
         x_cnt_ff  <= 15'd0;
         y_cnt_ff  <= 15'd0;
         x_sum_ff  <= 16'd0;
         y_sum_ff  <= 16'd0;
         x_pend_ff <= 16'd0;
         y_pend_ff <= 16'd0;
         pan_ff    <= PAN_POS_RST;
         tilt_ff   <= TILT_POS_RST;
         y_end_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         start_ff  <= start_in;
         x_act_ff  <= x_act_in;
         y_act_ff  <= y_act_in;
         x_cnt_ff  <= x_cnt_in;
         y_cnt_ff  <= y_cnt_in;
         x_sum_ff  <= x_sum_in;
         y_sum_ff  <= y_sum_in;
         x_pend_ff <= x_pend_in;
         y_pend_ff <= y_pend_in;
         pan_ff    <= pan_in;
         tilt_ff   <= tilt_in;
         y_end_ff  <= y_end_in;
      end
      x_num_ff <= x_num_in;
      y_num_ff <= y_num_in;
      x_den_ff <= x_den_in;
      y_den_ff <= y_den_in;
   end

   assign req_full = (state_ff != F_IDLE);

endmodule

`default_nettype wire

@@ rtl/mgsc_cmdq.sv @@
// two-entry command queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module mgsc_cmdq import mgsc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_data,
   output logic         full,
   input  wire logic    pop,
   output cmd_type      head,
   output logic         empty
);

   cmd_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

@@ rtl/mgsc_back.sv @@
// back end: packet serializer with registered output word
`timescale 1ns / 1ps
`default_nettype none

module mgsc_back import mgsc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    q_empty,
   input  wire cmd_type q_head,
   output logic         q_pop,
   output logic         rsp_empty,
   output rsp_type      rsp_data,
   input  wire logic    rsp_pop
);

   back_state_type state_ff, state_in;
   logic [3:0]     idx_ff, idx_in;
   logic           out_vld_ff, out_vld_in;
   rsp_type        out_ff, out_in;

   logic       load;
   logic [7:0] wr_id;
   logic [9:0] wr_pos;
   logic [7:0] wr_byte;
   logic [7:0] act_byte;

   always_comb begin
      wr_id  = (state_ff == B_TILT) ? cfg.tilt_id : cfg.pan_id;
      wr_pos = (state_ff == B_TILT) ? q_head.tilt_pos : q_head.pan_pos;
      case (idx_ff) inside
         4'd0, 4'd1: wr_byte = SYNC_BYTE;
         4'd2:       wr_byte = wr_id;
         4'd3:       wr_byte = WR_LEN;
         4'd4:       wr_byte = WR_INST;
         4'd5:       wr_byte = WR_ADDR;
         4'd6:       wr_byte = wr_pos[7:0];
         4'd7:       wr_byte = {6'd0, wr_pos[9:8]};
         4'd8:       wr_byte = WR_SPD_LO;
         4'd9:       wr_byte = WR_SPD_HI;
         default:    wr_byte = ~(wr_id + wr_pos[7:0] + {6'd0, wr_pos[9:8]} + WR_SUM_FIX);
      endcase
      case (idx_ff) inside
         4'd0, 4'd1: act_byte = SYNC_BYTE;
         4'd2:       act_byte = BCAST_ID;
         4'd3:       act_byte = ACT_LEN;
         4'd4:       act_byte = ACT_INST;
         default:    act_byte = ACT_CHK;
      endcase
   end

   assign load = !out_vld_ff || rsp_pop;

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      out_vld_in = out_vld_ff;
      out_in     = out_ff;
      q_pop      = 1'b0;
      if (load) out_vld_in = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               idx_in = 4'd0;
               if (q_head.pan_go)       state_in = B_PAN;
               else if (q_head.tilt_go) state_in = B_TILT;
               else                     state_in = B_ACT;
            end
         end
         B_PAN, B_TILT: begin
            if (load) begin
               out_vld_in       = 1'b1;
               out_in.tx_byte   = wr_byte;
               out_in.last_byte = 1'b0;
               if (idx_ff == WR_LAST_IDX) begin
                  idx_in   = 4'd0;
                  state_in = (state_ff == B_PAN && q_head.tilt_go) ? B_TILT : B_ACT;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
         end
         B_ACT: begin
            if (load) begin
               out_vld_in       = 1'b1;
               out_in.tx_byte   = act_byte;
               out_in.last_byte = (idx_ff == ACT_LAST_IDX);
               if (idx_ff == ACT_LAST_IDX) begin
                  q_pop    = 1'b1;
                  state_in = B_IDLE;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= B_IDLE;
         idx_ff     <= 4'd0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         out_vld_ff <= out_vld_in;
      end
      out_ff <= out_in;
   end

   assign rsp_empty = !out_vld_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

@@ rtl/mouse_gesture_servo_commander_top.sv @@
// top level: configuration registers, front end, command queue and packet back end
//
// req_push/req_full take one word per frame: mouse_x and mouse_y motion.
// rsp_empty/rsp_pop hand out the packet bytes, one word per byte; last_byte
// marks the final byte caused by a frame. Each frame gives 6, 17 or 28 bytes:
// an 11-byte write packet per servo that moves, then a 6-byte action packet.
// csr_we/csr_index/csr_wdata write the registers; write them only while idle.
// The front end runs the shared divider for each axis whose gesture ends,
// and the divider yields one quotient bit per cycle; req_full is high
// from the accepting edge until the frame's moves are queued.
// The back end emits one byte per cycle while the receiver keeps taking
// them, and passes through an idle state between frames.
// A two-entry queue sits between the two ends; when the receiver stalls,
// the output word holds, the queue fills and req_full stays high.
// Reset is synchronous: registers return to their defaults, gestures and
// pending averages clear, pan goes to 550 and tilt to 512, and no word waits.
`timescale 1ns / 1ps
`default_nettype none

module mouse_gesture_servo_commander_top import mgsc_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_push,
   input  wire req_type                req_data,
   output logic                        req_full,
   output logic                        rsp_empty,
   output rsp_type                     rsp_data,
   input  wire logic                   rsp_pop,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg_ff, cfg_in;

   logic    q_push, q_full, q_pop, q_empty;
   cmd_type q_wdata, q_head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DEAD_ZONE: cfg_in.dead_zone = csr_wdata[7:0];
            CSR_PAN_MAX:   cfg_in.pan_max   = csr_wdata;
            CSR_PAN_MIN:   cfg_in.pan_min   = csr_wdata;
            CSR_TILT_MAX:  cfg_in.tilt_max  = csr_wdata;
            CSR_TILT_MIN:  cfg_in.tilt_min  = csr_wdata;
            CSR_PAN_ID:    cfg_in.pan_id    = csr_wdata[7:0];
            CSR_TILT_ID:   cfg_in.tilt_id   = csr_wdata[7:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{dead_zone: DEAD_ZONE_RST, pan_max: PAN_MAX_RST, pan_min: PAN_MIN_RST,
                     tilt_max: TILT_MAX_RST, tilt_min: TILT_MIN_RST,
                     pan_id: PAN_ID_RST, tilt_id: TILT_ID_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mgsc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_push   (q_push),
      .q_data   (q_wdata),
      .q_full   (q_full)
   );

   mgsc_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   mgsc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop)
   );

endmodule

`default_nettype wire

@@ rtl/mgsc_checker.sv @@
// port-level checker for the mouse gesture servo commander, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module mgsc_checker import mgsc_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_push,
   input wire logic    req_full,
   input wire logic    rsp_empty,
   input wire rsp_type rsp_data,
   input wire logic    rsp_pop
);

   // nothing waits right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result word present after reset");

   // a waiting word holds until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result word changed");

   // the front end is busy in the cycle after it takes a frame
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> req_full)
      else $error("input taken twice in a row");

   // a frame always ends with the action checksum
   a_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.last_byte) |-> (rsp_data.tx_byte == ACT_CHK))
      else $error("last word is not the action checksum");

   // the word after a frame's last byte opens a packet
   a_sync: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && rsp_data.last_byte)
      |=> (rsp_empty || rsp_data.tx_byte == SYNC_BYTE))
      else $error("packet does not start with sync byte");

endmodule

bind mouse_gesture_servo_commander_top mgsc_checker u_mgsc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_data  (rsp_data),
   .rsp_pop   (rsp_pop)
);

`default_nettype wire

@@ sim/tb_top.sv @@
// self-checking testbench for the mouse gesture servo commander: directed, gesture, stall and random traffic
`timescale 1ns / 1ps
`default_nettype none

module tb_top import mgsc_pkg::*; ();

   localparam logic [2:0]  CSR_SPARE     = 3'd7;
   localparam logic [7:0]  PKT_SYNC      = 8'hFF;
   localparam logic [7:0]  PKT_LEN_WR    = 8'h07;
   localparam logic [7:0]  PKT_INST_WR   = 8'h04;
   localparam logic [7:0]  PKT_REG_POS   = 8'h1E;
   localparam logic [7:0]  PKT_SPEED_LO  = 8'hFF;
   localparam logic [7:0]  PKT_SPEED_HI  = 8'h03;
   localparam logic [7:0]  PKT_BCAST     = 8'hFE;
   localparam logic [7:0]  PKT_LEN_ACT   = 8'h02;
   localparam logic [7:0]  PKT_INST_ACT  = 8'h05;
   localparam logic [7:0]  PKT_CHK_ACT   = 8'hFA;
   localparam logic [14:0] SAMPLE_LIMIT  = 15'h7FFF;
   localparam int          LONG_STALL    = 400;
   localparam int          DRAIN_CYCLES  = 60;
   localparam int          LONG_GESTURE  = 30;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_push  = 1'b0;
   req_type                req_data  = '0;
   logic                   req_full;
   logic                   rsp_empty;
   rsp_type                rsp_data;
   logic                   rsp_pop   = 1'b0;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // predicted block state
   cfg_type     servo_cfg;
   bit          x_active, y_active;
   logic [14:0] x_count, y_count;
   logic [15:0] x_sum, y_sum;
   int          x_avg, y_avg;
   logic [9:0]  pan_pos, tilt_pos;
   rsp_type     bytes_due[$];

   int send_idle_pct = 0;
   int pop_idle_pct  = 0;
   int stall_asked   = 0;
   int stall_taken   = 0;
   int stall_left    = 0;
   int frames_sent   = 0;
   int bytes_checked = 0;
   int pan_moves     = 0;
   int tilt_moves    = 0;
   int error_count   = 0;

   mouse_gesture_servo_commander_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic reset_predictor();
      servo_cfg.dead_zone = 8'd5;
      servo_cfg.pan_max   = 10'd850;
      servo_cfg.pan_min   = 10'd240;
      servo_cfg.tilt_max  = 10'd812;
      servo_cfg.tilt_min  = 10'd212;
      servo_cfg.pan_id    = 8'd1;
      servo_cfg.tilt_id   = 8'd2;
      x_active = 1'b0;  y_active = 1'b0;
      x_count  = '0;    y_count  = '0;
      x_sum    = '0;    y_sum    = '0;
      x_avg    = 0;     y_avg    = 0;
      pan_pos  = 10'd550;
      tilt_pos = 10'd512;
   endtask

   function automatic void gesture_step(input logic [15:0] motion, inout bit active,
                                        inout logic [14:0] count, inout logic [15:0] sum,
                                        inout int avg);
      int total;
      if (motion != 16'd0) begin
         active = 1'b1;
         if (count != SAMPLE_LIMIT) count = count + 15'd1;
         sum = sum + motion;
      end else if (active) begin
         total = int'($signed(sum));
         avg = (count != 15'd0) ? total / int'(count) : 0;
         active = 1'b0;
         count = '0;
         sum = '0;
      end
   endfunction

   function automatic bit beyond_dead_zone(input int avg);
      return ((avg < 0) ? -avg : avg) > int'(servo_cfg.dead_zone);
   endfunction

   function automatic logic [9:0] clamp_position(input int target, input logic [9:0] hi,
                                                 input logic [9:0] lo);
      if (target > int'(hi)) target = int'(hi);
      if (target < int'(lo)) target = int'(lo);
      return 10'(target);
   endfunction

   function automatic void queue_byte(input logic [7:0] b, input logic last);
      rsp_type r;
      r.tx_byte = b;
      r.last_byte = last;
      bytes_due.push_back(r);
   endfunction

   function automatic void queue_write_packet(input logic [7:0] id, input logic [9:0] pos);
      logic [7:0] body[8];
      logic [7:0] chk;
      body = '{id, PKT_LEN_WR, PKT_INST_WR, PKT_REG_POS, pos[7:0], {6'd0, pos[9:8]},
               PKT_SPEED_LO, PKT_SPEED_HI};
      chk = 8'd0;
      queue_byte(PKT_SYNC, 1'b0);
      queue_byte(PKT_SYNC, 1'b0);
      foreach (body[i]) begin
         chk = chk + body[i];
         queue_byte(body[i], 1'b0);
      end
      queue_byte(~chk, 1'b0);
   endfunction

   function automatic void predict_packets(input req_type w);
      gesture_step(w.mouse_x, x_active, x_count, x_sum, x_avg);
      gesture_step(w.mouse_y, y_active, y_count, y_sum, y_avg);
      if (beyond_dead_zone(x_avg)) begin
         pan_pos = clamp_position(int'(pan_pos) - x_avg, servo_cfg.pan_max, servo_cfg.pan_min);
         x_avg = 0;
         queue_write_packet(servo_cfg.pan_id, pan_pos);
         pan_moves++;
      end
      if (beyond_dead_zone(y_avg)) begin
         tilt_pos = clamp_position(int'(tilt_pos) + y_avg, servo_cfg.tilt_max,
                                   servo_cfg.tilt_min);
         y_avg = 0;
         queue_write_packet(servo_cfg.tilt_id, tilt_pos);
         tilt_moves++;
      end
      queue_byte(PKT_SYNC, 1'b0);
      queue_byte(PKT_SYNC, 1'b0);
      queue_byte(PKT_BCAST, 1'b0);
      queue_byte(PKT_LEN_ACT, 1'b0);
      queue_byte(PKT_INST_ACT, 1'b0);
      queue_byte(PKT_CHK_ACT, 1'b1);
   endfunction

   function automatic void store_reg(input logic [2:0] idx, input logic [9:0] data);
      case (idx)
         CSR_DEAD_ZONE: servo_cfg.dead_zone = data[7:0];
         CSR_PAN_MAX:   servo_cfg.pan_max   = data;
         CSR_PAN_MIN:   servo_cfg.pan_min   = data;
         CSR_TILT_MAX:  servo_cfg.tilt_max  = data;
         CSR_TILT_MIN:  servo_cfg.tilt_min  = data;
         CSR_PAN_ID:    servo_cfg.pan_id    = data[7:0];
         CSR_TILT_ID:   servo_cfg.tilt_id   = data[7:0];
         default: ;
      endcase
   endfunction

   task automatic send_word(input int mx, input int my);
      req_type w;
      w.mouse_x = 16'(mx);
      w.mouse_y = 16'(my);
      if ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_full);
      predict_packets(w);
      frames_sent++;
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      while (bytes_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [9:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      store_reg(idx, data);
   endtask

   // 8-bit registers get random junk in the unused upper bits
   task automatic apply_config(input cfg_type c);
      wait_idle();
      write_reg(CSR_DEAD_ZONE, {2'($urandom), c.dead_zone});
      write_reg(CSR_PAN_MAX, c.pan_max);
      write_reg(CSR_PAN_MIN, c.pan_min);
      write_reg(CSR_TILT_MAX, c.tilt_max);
      write_reg(CSR_TILT_MIN, c.tilt_min);
      write_reg(CSR_PAN_ID, {2'($urandom), c.pan_id});
      write_reg(CSR_TILT_ID, {2'($urandom), c.tilt_id});
      write_reg(CSR_SPARE, 10'($urandom));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic cfg_type random_config();
      cfg_type c;
      c.dead_zone = 8'($urandom_range(0, 30));
      c.pan_min   = 10'($urandom_range(0, 500));
      c.pan_max   = 10'($urandom_range(c.pan_min, 1023));
      c.tilt_min  = 10'($urandom_range(0, 500));
      c.tilt_max  = 10'($urandom_range(c.tilt_min, 1023));
      if ($urandom_range(4) == 0) c.tilt_max = 10'($urandom_range(0, 1023));
      c.pan_id    = 8'($urandom);
      c.tilt_id   = 8'($urandom);
      return c;
   endfunction

   // one axis sample: mostly gestures of random length split by zeros, some raw noise
   function automatic int gesture_sample(inout int run);
      int v;
      if ($urandom_range(19) == 0) return int'($urandom_range(0, 65535));
      if (run == 0) begin
         if ($urandom_range(3) != 0) run = ($urandom_range(7) == 0) ? $urandom_range(7, 40)
                                                                     : $urandom_range(1, 6);
         return 0;
      end
      run--;
      case ($urandom_range(9))
         0:       v = int'($urandom_range(1, 65535));
         1:       v = int'($urandom_range(100, 2000));
         default: v = int'($urandom_range(1, 80));
      endcase
      if ($urandom_range(1) == 1) v = -v;
      if (16'(v) == 16'd0) v = 1;
      return v;
   endfunction

   task automatic test_directed_moves();
      send_idle_pct = 29;
      pop_idle_pct <= 50;
      send_word(0, 0);
      send_word(100, 0);
      send_word(0, 0);
      send_word(32767, -32768);
      send_word(0, 0);
      send_word(-32768, 32767);
      send_word(0, 0);
      send_word(-7, 30000);
      send_word(-2, 30000);
      send_word(0, 0);
      send_word(3, 0);
      send_word(0, 40);
      send_word(50, 0);
      send_word(0, 0);
      send_word(1, -3);
      send_word(0, 0);
   endtask

   // averages left pending inside the dead zone move once it is lowered
   task automatic test_small_average();
      cfg_type c;
      c = servo_cfg;
      c.dead_zone = 8'd0;
      apply_config(c);
      send_word(0, 0);
   endtask

   task automatic test_register_extremes();
      cfg_type c;
      c.dead_zone = 8'd255;
      c.pan_max   = 10'd100;
      c.pan_min   = 10'd900;
      c.tilt_max  = 10'd0;
      c.tilt_min  = 10'd1023;
      c.pan_id    = 8'hFF;
      c.tilt_id   = 8'hFE;
      apply_config(c);
      send_word(255, -255);
      send_word(0, 0);
      send_word(-600, 600);
      send_word(0, 0);
      c.dead_zone = 8'd0;
      c.pan_max   = 10'd1023;
      c.pan_min   = 10'd0;
      c.tilt_max  = 10'd1023;
      c.tilt_min  = 10'd0;
      c.pan_id    = 8'd0;
      c.tilt_id   = 8'd253;
      apply_config(c);
      send_word(1, -1);
      send_word(0, 0);
      send_word(2000, -2000);
      send_word(0, 0);
   endtask

   // a longer gesture of wide samples; the last one steers the sums to the extremes
   task automatic test_long_gesture();
      logic [15:0] sx, sy, vx, vy;
      int i;
      cfg_type c;
      c = random_config();
      c.dead_zone = 8'd0;
      apply_config(c);
      send_idle_pct = 0;
      pop_idle_pct <= 0;
      sx = '0;
      sy = '0;
      for (i = 0; i < LONG_GESTURE; i++) begin
         vx = 16'($urandom_range(1, 65535));
         vy = 16'($urandom_range(1, 65535));
         if (i == LONG_GESTURE - 1) begin
            vx = 16'h8000 - sx;
            vy = 16'h7FFF - sy;
         end
         if (vx == 16'd0) vx = 16'd1;
         if (vy == 16'd0) vy = 16'd1;
         sx = sx + vx;
         sy = sy + vy;
         send_word(int'(vx), int'(vy));
      end
      send_word(0, 0);
   endtask

   task automatic test_backpressure();
      int x_run, y_run;
      apply_config(random_config());
      send_idle_pct = 0;
      pop_idle_pct <= 0;
      stall_asked <= stall_asked + 1;
      x_run = 3;
      y_run = 2;
      repeat (12) send_word(gesture_sample(x_run), gesture_sample(y_run));
      wait_idle();
   endtask

   task automatic test_random_traffic(input int items, input int send_pct, input int pop_pct);
      int x_run, y_run;
      apply_config(random_config());
      send_idle_pct = send_pct;
      pop_idle_pct <= pop_pct;
      x_run = 0;
      y_run = 0;
      repeat (items) send_word(gesture_sample(x_run), gesture_sample(y_run));
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (bytes_due.size() == 0) begin
               $error("tx_byte 0x%02h arrived with no word due", rsp_data.tx_byte);
               error_count++;
            end else begin
               want = bytes_due.pop_front();
               if (rsp_data.tx_byte !== want.tx_byte) begin
                  $error("tx_byte: expected 0x%02h, got 0x%02h", want.tx_byte, rsp_data.tx_byte);
                  error_count++;
               end
               if (rsp_data.last_byte !== want.last_byte) begin
                  $error("last_byte: expected %0b, got %0b", want.last_byte, rsp_data.last_byte);
                  error_count++;
               end
               bytes_checked++;
            end
         end
         if (stall_asked != stall_taken) begin
            stall_taken <= stall_asked;
            stall_left  <= LONG_STALL;
            rsp_pop     <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_pop    <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= pop_idle_pct);
         end
      end
   end

   initial begin
      reset_predictor();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed_moves();
      test_small_average();
      test_register_extremes();
      test_long_gesture();
      test_backpressure();
      test_random_traffic(60, 29, 88);
      test_random_traffic(60, 88, 29);
      test_random_traffic(60, 0, 0);
      req_push <= 1'b0;
      while (bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d frames, %0d packet bytes checked, %0d pan and %0d tilt moves",
               frames_sent, bytes_checked, pan_moves, tilt_moves);
      $display("covered clamp extremes, crossed clamps, long wrapping gestures and a long output stall");
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire
